### hw/rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared definitions for the point-in-polygon tester
// Operation codes of the input channel and the control group that the
// sequencer drives into the crossing unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

  // Operation codes carried by in_op. The fourth code is ignored.
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Per-cycle commands for the crossing unit.
  typedef struct packed {
    logic load;        // capture edge operands from the current vertex pair
    logic mul_first;   // multiply row offset by edge x span
    logic mul_second;  // multiply point x offset by edge y span
  } pip_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/pip_vstore.sv
// ----------------------------------------------------------------------------
// pip_vstore: polygon vertex memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_vstore #(
  parameter int DEPTH = 16,
  parameter int W     = 16,
  parameter int IW    = 4
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [IW-1:0]        waddr,
  input  wire logic signed [W-1:0]  wx,
  input  wire logic signed [W-1:0]  wy,
  input  wire logic [IW-1:0]        raddr,
  output logic signed [W-1:0]       rx,
  output logic signed [W-1:0]       ry
);

  logic signed [W-1:0] mem_x [DEPTH];
  logic signed [W-1:0] mem_y [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= wx;
      mem_y[waddr] <= wy;
    end
  end

  always_ff @(posedge clk) begin
    rx <= mem_x[raddr];
    ry <= mem_y[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/pip_cross.sv
// ----------------------------------------------------------------------------
// pip_cross: edge crossing test with one shared multiplier
// Prepares the operands of one edge, forms both cross products one after
// the other on a single multiplier and compares them in the cycle after the second.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_cross
  import pip_pkg::*;
#(
  parameter int W = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pip_ctl_t            ctl,
  input  wire logic signed [W-1:0] cur_x,
  input  wire logic signed [W-1:0] cur_y,
  input  wire logic signed [W-1:0] prev_x,
  input  wire logic signed [W-1:0] prev_y,
  input  wire logic signed [W-1:0] pt_x,
  input  wire logic signed [W-1:0] pt_y,
  output logic                     toggle
);

  localparam int EW = W + 1;
  localparam int PW = 2 * EW;

  logic signed [EW-1:0] xi_e, yi_e, xj_e, yj_e, px_e, py_e;
  logic signed [EW-1:0] a_raw, d_raw, a_adj, d_adj, dx, ex;
  logic                 spans, left, hit;

  logic signed [EW-1:0] a_r, d_r, dx_r, ex_r;
  logic                 hit_r, pend_r;
  logic signed [EW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] p1_r, p2_r;

  assign xi_e = {cur_x[W-1], cur_x};
  assign yi_e = {cur_y[W-1], cur_y};
  assign xj_e = {prev_x[W-1], prev_x};
  assign yj_e = {prev_y[W-1], prev_y};
  assign px_e = {pt_x[W-1], pt_x};
  assign py_e = {pt_y[W-1], pt_y};

  // The row crosses the edge when it lies strictly above one end and at or
  // below the other; one end must also sit at or left of the point.
  assign spans = ((cur_y < pt_y) && (prev_y >= pt_y)) ||
                 ((prev_y < pt_y) && (cur_y >= pt_y));
  assign left  = (cur_x <= pt_x) || (prev_x <= pt_x);
  assign hit   = spans && left;

  // Make the y span positive so the compare needs no sign flip.
  assign a_raw = py_e - yi_e;
  assign d_raw = yj_e - yi_e;
  assign a_adj = d_raw[EW-1] ? -a_raw : a_raw;
  assign d_adj = d_raw[EW-1] ? -d_raw : d_raw;
  assign dx    = xj_e - xi_e;
  assign ex    = px_e - xi_e;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r  <= a_adj;
      d_r  <= d_adj;
      dx_r <= dx;
      ex_r <= ex;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (ctl.load) begin
        hit_r <= hit;
      end
      pend_r <= ctl.mul_second && hit_r;
    end
  end

  assign mul_a = ctl.mul_second ? ex_r : a_r;
  assign mul_b = ctl.mul_second ? d_r  : dx_r;
  assign prod  = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (ctl.mul_first) begin
      p1_r <= prod;
    end
    if (ctl.mul_second) begin
      p2_r <= prod;
    end
  end

  // Crossing strictly left of the point.
  assign toggle = pend_r && (p1_r < p2_r);

endmodule

`default_nettype wire

### hw/rtl/point_in_polygon_even_odd.sv
// ----------------------------------------------------------------------------
// point_in_polygon_even_odd: even-odd point-in-polygon tester
// Append and clear beats give no result beat.
// A query reads the last stored vertex, then walks each edge through
// operand setup and two products on the single shared multiplier and
// loads its result beat in a done state; an empty polygon skips the walk.
// Input stalls from query acceptance until its result is loaded.
// Synchronous active-low reset empties the polygon and clears the flag.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_even_odd
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_op,
  input  wire logic signed [COORD_WIDTH-1:0] in_vertex_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_vertex_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_inside_res,
  output logic                               out_truncated
);

  localparam int W  = COORD_WIDTH;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int IW = $clog2(MAX_VERTICES);

  // The sequencer walks the edges in the order last-to-first, then each
  // later pair. The vertex read for the next edge is issued in the last
  // cycle of the current edge, so memory latency is hidden.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREV,
    S_EDGE,
    S_MUL1,
    S_MUL2,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                dropped_r, dropped_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic                inside_r, inside_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_inside_r, out_inside_nxt;
  logic                out_trunc_r, out_trunc_nxt;
  logic signed [W-1:0] pt_x_r, pt_x_nxt;
  logic signed [W-1:0] pt_y_r, pt_y_nxt;
  logic signed [W-1:0] prev_x_r, prev_x_nxt;
  logic signed [W-1:0] prev_y_r, prev_y_nxt;

  logic                in_acc;
  logic                out_free;
  logic [CW-1:0]       last_idx;
  logic                is_last;
  logic                mem_we;
  logic [IW-1:0]       raddr;
  logic signed [W-1:0] rd_x, rd_y;
  pip_ctl_t            ctl;
  logic                toggle;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign last_idx = count_r - CW'(1);
  assign is_last  = (CW'(idx_r) == last_idx);

  // An append lands in the next free slot; a full store drops it.
  assign mem_we = in_acc && (in_op == OP_APPEND) && (count_r < CW'(MAX_VERTICES));

  pip_vstore #(
    .DEPTH (MAX_VERTICES),
    .W     (W),
    .IW    (IW)
  ) u_vstore (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[IW-1:0]),
    .wx    (in_vertex_x),
    .wy    (in_vertex_y),
    .raddr (raddr),
    .rx    (rd_x),
    .ry    (rd_y)
  );

  pip_cross #(
    .W (W)
  ) u_cross (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .cur_x  (rd_x),
    .cur_y  (rd_y),
    .prev_x (prev_x_r),
    .prev_y (prev_y_r),
    .pt_x   (pt_x_r),
    .pt_y   (pt_y_r),
    .toggle (toggle)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    dropped_nxt    = dropped_r;
    idx_nxt        = idx_r;
    inside_nxt     = inside_r ^ toggle;
    out_valid_nxt  = out_valid_r && out_stall;
    out_inside_nxt = out_inside_r;
    out_trunc_nxt  = out_trunc_r;
    pt_x_nxt       = pt_x_r;
    pt_y_nxt       = pt_y_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    ctl            = '0;
    // While idle, keep the last vertex on the read port so a query can
    // start from it right away.
    raddr          = last_idx[IW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_APPEND: begin
              if (count_r < CW'(MAX_VERTICES)) begin
                count_nxt = count_r + CW'(1);
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            OP_QUERY: begin
              pt_x_nxt   = in_point_x;
              pt_y_nxt   = in_point_y;
              inside_nxt = 1'b0;
              idx_nxt    = '0;
              state_nxt  = (count_r == '0) ? S_DONE : S_PREV;
            end
            OP_CLEAR: begin
              count_nxt   = '0;
              dropped_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_PREV: begin
        prev_x_nxt = rd_x;
        prev_y_nxt = rd_y;
        raddr      = '0;
        state_nxt  = S_EDGE;
      end
      S_EDGE: begin
        // The read port holds vertex idx; it becomes the trailing end of
        // the following edge.
        ctl.load   = 1'b1;
        prev_x_nxt = rd_x;
        prev_y_nxt = rd_y;
        state_nxt  = S_MUL1;
      end
      S_MUL1: begin
        ctl.mul_first = 1'b1;
        state_nxt     = S_MUL2;
      end
      S_MUL2: begin
        ctl.mul_second = 1'b1;
        raddr          = IW'(idx_r + IW'(1));
        if (is_last) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = IW'(idx_r + IW'(1));
          state_nxt = S_EDGE;
        end
      end
      S_DONE: begin
        // The last edge's toggle arrives in the first cycle here, so the
        // result is taken from the updated flag.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = inside_nxt;
          out_trunc_nxt  = dropped_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      idx_r       <= '0;
      inside_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      idx_r       <= idx_nxt;
      inside_r    <= inside_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_inside_r <= out_inside_nxt;
    out_trunc_r  <= out_trunc_nxt;
    pt_x_r       <= pt_x_nxt;
    pt_y_r       <= pt_y_nxt;
    prev_x_r     <= prev_x_nxt;
    prev_y_r     <= prev_y_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_truncated  = out_trunc_r;

  // A result beat is only ever raised by the final state of a query.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside of query completion");

  // The store never claims more vertices than it holds.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  // The edge walk only reads written entries.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDGE) |-> (CW'(idx_r) < count_r))
    else $error("edge walk beyond stored vertices");

  // The overflow flag is set only by an append to a full store.
  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(dropped_r) |-> $past(count_r == CW'(MAX_VERTICES)))
    else $error("overflow flag set with room left");

endmodule

`default_nettype wire

### tb/sv/pip_result_checker.sv
// ----------------------------------------------------------------------------
// pip_result_checker: scoreboard for the point-in-polygon tester
// Watches both channels, keeps its own polygon store, works out the even-odd
// answer of every accepted query and compares it with the returned beat.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_result_checker
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic [1:0]                    in_op,
  input  wire logic signed [COORD_WIDTH-1:0] in_vertex_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_vertex_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_y,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic                          out_inside_res,
  input  wire logic                          out_truncated,
  output int                                 fail_count,
  output int                                 pending_results
);

  // Wide enough for the product of two coordinate differences.
  localparam int PW = 2 * COORD_WIDTH + 4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PW-1:0]          wide_t;

  typedef struct packed {
    logic inside_res;
    logic truncated;
  } pip_answer_t;

  coord_t      poly_x [MAX_VERTICES];
  coord_t      poly_y [MAX_VERTICES];
  int          vertex_count;
  logic        appends_dropped;
  int          mismatches;
  pip_answer_t answer_q [$];

  // Crossing-number test with the crossing position compared exactly by
  // cross-multiplication, the edge's y span made positive first.
  function automatic logic even_odd_inside(coord_t px, coord_t py);
    wide_t xi, yi, xj, yj, wx, wy, rise, span;
    logic  odd_cross;
    logic  spans;
    int    j;
    odd_cross = 1'b0;
    wx        = px;
    wy        = py;
    j         = vertex_count - 1;
    for (int i = 0; i < vertex_count; i++) begin
      xi    = poly_x[i];
      yi    = poly_y[i];
      xj    = poly_x[j];
      yj    = poly_y[j];
      spans = (yi < wy && yj >= wy) || (yj < wy && yi >= wy);
      if (spans && (xi <= wx || xj <= wx)) begin
        rise = wy - yi;
        span = yj - yi;
        if (span < 0) begin
          rise = -rise;
          span = -span;
        end
        if (rise * (xj - xi) < (wx - xi) * span) odd_cross = !odd_cross;
      end
      j = i;
    end
    return odd_cross;
  endfunction

  always @(posedge clk) begin
    pip_answer_t want;
    if (!rst_n) begin
      answer_q.delete();
      vertex_count    = 0;
      appends_dropped = 1'b0;
      mismatches      = 0;
      fail_count      <= 0;
      pending_results <= 0;
    end else begin
      // The result side goes first: a beat leaving now can only belong to
      // a query accepted at an earlier edge.
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          $error("result beat with no query waiting: inside_res %0b truncated %0b",
                 out_inside_res, out_truncated);
          mismatches++;
        end else begin
          want = answer_q.pop_front();
          if (out_inside_res !== want.inside_res) begin
            $error("inside_res: expected %0b, actual %0b", want.inside_res, out_inside_res);
            mismatches++;
          end
          if (out_truncated !== want.truncated) begin
            $error("truncated: expected %0b, actual %0b", want.truncated, out_truncated);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_op)
          OP_APPEND: begin
            if (vertex_count < MAX_VERTICES) begin
              poly_x[vertex_count] = in_vertex_x;
              poly_y[vertex_count] = in_vertex_y;
              vertex_count++;
            end else begin
              appends_dropped = 1'b1;
            end
          end
          OP_QUERY: begin
            want.inside_res = even_odd_inside(in_point_x, in_point_y);
            want.truncated  = appends_dropped;
            answer_q.insert(answer_q.size(), want);
          end
          OP_CLEAR: begin
            vertex_count    = 0;
            appends_dropped = 1'b0;
          end
          default: ;
        endcase
      end
      fail_count      <= mismatches;
      pending_results <= answer_q.size();
    end
  end

endmodule

`default_nettype wire

### tb/sv/tb_point_in_polygon_even_odd.sv
// ----------------------------------------------------------------------------
// tb_point_in_polygon_even_odd: testbench of the point-in-polygon tester
// Loads polygons of many shapes and sizes, queries points against them and
// lets a scoreboard check every answer, under random sender bursts and
// receiver stalls, one long receiver hold and a full drain midway through.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_point_in_polygon_even_odd;
  import pip_pkg::*;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_WIDTH  = 16;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // The fourth op code; the block must ignore it.
  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

  // Stimulus stops once this many append, query and clear beats have gone
  // in: roughly thirty directed ones followed by about four hundred random.
  localparam int TOTAL_ITEMS  = 430;
  // Length of the one long receiver hold.
  localparam int HOLD_CYCLES  = 300;
  // The tail gives a query over a full store time to finish.
  localparam int TAIL_CYCLES  = 3 * MAX_VERTICES + 8;
  // Cycles without any accepted beat before the run is declared hung. The
  // worst correct stretch is the long hold plus one full query.
  localparam int QUIET_LIMIT  = 4000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  coord_t      in_vertex_x;
  coord_t      in_vertex_y;
  coord_t      in_point_x;
  coord_t      in_point_y;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_inside_res;
  logic        out_truncated;

  int          fail_count;
  int          pending_results;
  int          items_sent   = 0;
  int          burst_left   = 1;
  int          quiet_cycles = 0;
  int          hold_left;
  int          phase_cnt;
  bit          pacing_on    = 1'b1;
  bit          hold_req     = 1'b0;
  bit          hold_taken;
  stall_mode_e stall_mode;

  always #1 clk = ~clk;

  point_in_polygon_even_odd #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_inside_res (out_inside_res),
    .out_truncated  (out_truncated)
  );

  // The scoreboard sits beside the block and sees exactly what it sees.
  pip_result_checker #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_vertex_x     (in_vertex_x),
    .in_vertex_y     (in_vertex_y),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_inside_res  (out_inside_res),
    .out_truncated   (out_truncated),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Receiver. Once the stimulus asks for it, the result side holds off for
  // a long stretch so that the block fills up and stalls its input. The
  // rest of the time it switches periodically between no stalls, light
  // and heavy random stalls, and a fixed pattern stalling more often than not.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      hold_left  = 0;
      phase_cnt  = 0;
      hold_taken = 1'b0;
      stall_mode = STALL_NONE;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      phase_cnt++;
      if (phase_cnt >= 97) begin
        phase_cnt  = 0;
        stall_mode = stall_mode_e'($urandom_range(0, 3));
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((phase_cnt % 5) < 3);
      endcase
    end
  end

  // Watchdog: a run that stops moving beats is a failure.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // A coordinate scattered around a center. One in eight is pinned to an
  // end of the range instead, and sums past the range simply wrap.
  function automatic coord_t near(int center, int spread);
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
    return coord_t'(center + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // Offers one beat and returns at the edge where it is accepted. The
  // coordinates go to the fields that the op uses; the other pair carries
  // noise, which the block must not look at. With pacing on, the sender
  // then works through its burst and may leave a gap before the next beat.
  task automatic send_beat(logic [1:0] op, coord_t x, coord_t y);
    int gap;
    in_op <= op;
    if (op == OP_QUERY) begin
      in_point_x  <= x;
      in_point_y  <= y;
      in_vertex_x <= coord_t'($urandom());
      in_vertex_y <= coord_t'($urandom());
    end else begin
      in_vertex_x <= x;
      in_vertex_y <= y;
      in_point_x  <= coord_t'($urandom());
      in_point_y  <= coord_t'($urandom());
    end
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op != OP_IGNORED) items_sent++;
    if (pacing_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
        gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 4);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    coord_t poly_x [32];
    coord_t poly_y [32];
    coord_t qx, qy;
    int     n_vert, n_query, cx, cy, spread, pick, k;
    bit     hold_asked, drained;

    cx         = 0;
    cy         = 0;
    spread     = 64;
    n_vert     = 1;
    hold_asked = 1'b0;
    drained    = 1'b0;

    in_valid    <= 1'b0;
    in_op       <= OP_APPEND;
    in_vertex_x <= '0;
    in_vertex_y <= '0;
    in_point_x  <= '0;
    in_point_y  <= '0;
    rst_n       <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A query straight out of reset sees an empty polygon,
    // and the unused op code must leave no trace.
    send_beat(OP_QUERY, 0, 0);
    send_beat(OP_IGNORED, 5, 5);

    // One vertex, then two: the edges collapse to a point or to a single
    // segment walked twice, so no point can come out inside.
    send_beat(OP_APPEND, COORD_MIN, COORD_MIN);
    send_beat(OP_QUERY, COORD_MIN, COORD_MIN);
    send_beat(OP_APPEND, COORD_MAX, COORD_MAX);
    send_beat(OP_QUERY, 0, 0);
    send_beat(OP_CLEAR, 0, 0);

    // The largest square the coordinates allow, probed at its center, on
    // its left and right sides and on its horizontal bottom and top edges.
    send_beat(OP_APPEND, COORD_MIN, COORD_MIN);
    send_beat(OP_APPEND, COORD_MAX, COORD_MIN);
    send_beat(OP_APPEND, COORD_MAX, COORD_MAX);
    send_beat(OP_APPEND, COORD_MIN, COORD_MAX);
    send_beat(OP_QUERY, 0, 0);
    send_beat(OP_QUERY, COORD_MIN, 0);
    send_beat(OP_QUERY, COORD_MAX, 0);
    send_beat(OP_QUERY, 0, COORD_MIN);
    send_beat(OP_QUERY, 0, COORD_MAX);

    // Fill the store, push one vertex too many, and check that the drop is
    // reported and then forgotten by a clear, which also empties the store.
    repeat (MAX_VERTICES - 4) send_beat(OP_APPEND, near(0, 20000), near(0, 20000));
    send_beat(OP_APPEND, 1, 1);
    send_beat(OP_QUERY, 0, 0);
    send_beat(OP_CLEAR, 0, 0);
    send_beat(OP_QUERY, 0, 0);

    // Random part. Most of it is whole sequences: clear, load a polygon,
    // then ask a few points about it. Some sequences skip the clear and
    // pile onto what is stored, and one step in ten sends a single noise beat.
    while (items_sent < TOTAL_ITEMS) begin
      if (!hold_asked && items_sent >= 150) begin
        // The receiver holds off while queries keep coming back to back,
        // so the result register stays full and the input stalls.
        hold_asked = 1'b1;
        hold_req   <= 1'b1;
        pacing_on  = 1'b0;
        repeat (12) send_beat(OP_QUERY, near(cx, spread), near(cy, spread));
        pacing_on  = 1'b1;
      end else if (!drained && items_sent >= 280) begin
        // The sender goes quiet until every answer is back.
        drained  = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
      end else if ($urandom_range(0, 9) == 0) begin
        send_beat(2'($urandom_range(0, 3)), coord_t'($urandom()), coord_t'($urandom()));
      end else begin
        if ($urandom_range(0, 9) != 0) send_beat(OP_CLEAR, coord_t'($urandom()), 0);
        pick   = $urandom_range(0, 9);
        n_vert = (pick == 0) ? $urandom_range(1, 2) :
                 (pick < 8)  ? $urandom_range(3, 8) : $urandom_range(14, 20);
        cx     = int'($urandom_range(0, 65535)) - 32768;
        cy     = int'($urandom_range(0, 65535)) - 32768;
        spread = 1 << $urandom_range(2, 15);
        for (k = 0; k < n_vert; k++) begin
          poly_x[k] = near(cx, spread);
          poly_y[k] = near(cy, spread);
          send_beat(OP_APPEND, poly_x[k], poly_y[k]);
        end
        // Queries reuse vertex coordinates often, so the ties on the row
        // and on the point's x are hit as well as the open cases.
        n_query = $urandom_range(1, 6);
        repeat (n_query) begin
          k    = $urandom_range(0, n_vert - 1);
          pick = $urandom_range(0, 5);
          case (pick)
            0: begin
              qx = poly_x[k];
              qy = poly_y[k];
            end
            1: begin
              qx = near(cx, spread);
              qy = poly_y[k];
            end
            2: begin
              qx = poly_x[k];
              qy = near(cy, spread);
            end
            3: begin
              qx = coord_t'($urandom());
              qy = coord_t'($urandom());
            end
            default: begin
              qx = near(cx, spread);
              qy = near(cy, spread);
            end
          endcase
          send_beat(OP_QUERY, qx, qy);
        end
      end
    end

    // Drain: wait for the last answers, then give the block time to show
    // any beat it should not send.
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
